FILE: rtl/ptg_pkg.sv
// ----------------------------------------------------------------------------
// ptg_pkg
// Shared types, register codes and fixed-point constants of the pixel to
// gripper position core.
// ----------------------------------------------------------------------------
package ptg_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_ROW_SPLIT   = 3'd0;
    localparam logic [2:0] REG_DEPTH_UPPER = 3'd1;
    localparam logic [2:0] REG_DEPTH_LOWER = 3'd2;
    localparam logic [2:0] REG_FOCAL_X     = 3'd3;
    localparam logic [2:0] REG_FOCAL_Y     = 3'd4;
    localparam logic [2:0] REG_CAM_Y       = 3'd5;
    localparam logic [2:0] REG_CAM_Z       = 3'd6;

    localparam int DIV_STEPS    = 28;
    localparam int CORDIC_STEPS = 30;

    // Claw geometry and rotation constants; the sine, cosine and gain constants are Q16.
    localparam longint CLAW_OFFSET_Y = 2176;
    localparam longint CLAW_OFFSET_Z = 294;
    localparam longint SIN80_Q16     = 64540;
    localparam longint COS80_Q16     = 11380;
    localparam longint INVK_Q16      = 39797;
    localparam longint ROLL_HEIGHT   = 6400;

    localparam longint S_HI = SIN80_Q16 * CLAW_OFFSET_Y + COS80_Q16 * CLAW_OFFSET_Z;
    localparam longint C_HI = SIN80_Q16 * CLAW_OFFSET_Z - COS80_Q16 * CLAW_OFFSET_Y;
    localparam longint S_LO = SIN80_Q16 * CLAW_OFFSET_Y - COS80_Q16 * CLAW_OFFSET_Z;
    localparam longint C_LO = SIN80_Q16 * CLAW_OFFSET_Z + COS80_Q16 * CLAW_OFFSET_Y;

    localparam longint OFFZ_HI  = (C_HI + 32768) >>> 16;
    localparam longint OFFZ_LO  = (C_LO + 32768) >>> 16;
    localparam longint OFFX0_HI = (S_HI + 32768) >>> 16;
    localparam longint OFFX0_LO = (S_LO + 32768) >>> 16;

    localparam logic signed [7:0] ROLL_HI = -8'sd80;
    localparam logic signed [7:0] ROLL_LO = -8'sd100;

    // Divider stage payload: two restoring divisions side by side.
    typedef struct packed {
        logic signed [16:0] by;
        logic [27:0]        nx;
        logic [27:0]        ny;
        logic [27:0]        qx;
        logic [27:0]        qy;
        logic [11:0]        rx;
        logic [11:0]        ry;
    } div_t;

    // CORDIC stage payload.
    typedef struct packed {
        logic signed [28:0] bx;
        logic signed [16:0] by;
        logic signed [29:0] bz;
        logic               high;
        logic               zero;
        logic signed [47:0] vx;
        logic signed [47:0] vy;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } cor_t;

    // Clamp to the 17-bit signed output range.
    function automatic logic [16:0] sat17(input logic signed [33:0] val);
        logic [16:0] res;
        if (val > 34'sd65535)
        begin
            res = 17'h0FFFF;
        end
        else if (val < -34'sd65536)
        begin
            res = 17'h10000;
        end
        else
        begin
            res = val[16:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/pixel_to_gripper_position_core.sv
// ----------------------------------------------------------------------------
// pixel_to_gripper_position_core
// Back-projects an image point to the arm base frame and applies the claw
// offset along the bearing of the point.
// ----------------------------------------------------------------------------
// The core takes one point per clock while the pipeline advances and
// returns one result per point, in order, after one input stage with the
// depth multiply, 28 restoring divider stages, a setup stage, 30 CORDIC
// vectoring stages, a scaling multiply stage and the output register. The
// whole pipeline advances whenever the output register is empty or being
// taken. Configuration must only be written while no point is in flight.
module pixel_to_gripper_position_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // pixel_x[11:0], pixel_y[23:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // grip_x[16:0], grip_y[33:17], grip_z[50:34],
                                    // roll_deg[58:51], zero pad[63:59]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ptg_pkg::*;

    logic [11:0] row_split_reg;
    logic [15:0] depth_upper_reg;
    logic [15:0] depth_lower_reg;
    logic [11:0] focal_x_reg;
    logic [11:0] focal_y_reg;
    logic [15:0] cam_y_reg;
    logic [15:0] cam_z_reg;

    logic [DIV_STEPS:0]    div_vld_reg;
    div_t                  div_reg  [0:DIV_STEPS];
    div_t                  div_next [0:DIV_STEPS];
    logic [CORDIC_STEPS:0] cor_vld_reg;
    cor_t                  cor_reg  [0:CORDIC_STEPS];
    cor_t                  cor_next [0:CORDIC_STEPS];

    logic                  mul_vld_reg;
    logic signed [49:0]    mulx_reg;
    logic signed [49:0]    muly_reg;
    cor_t                  mul_reg;
    logic                  out_vld_reg;
    logic [63:0]           out_data_reg;

    logic                  adv;
    logic [11:0]           fx;
    logic [11:0]           fy;
    logic [11:0]           pix_x;
    logic [11:0]           pix_y;
    logic [15:0]           depth;

    // Output stage terms.
    logic [63:0]           out_data_next;
    logic signed [49:0]    rx;
    logic signed [49:0]    ry;
    logic signed [17:0]    offx;
    logic signed [17:0]    offy;
    logic signed [17:0]    offz;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_split_reg   <= 12'd175;
            depth_upper_reg <= 16'd6272;
            depth_lower_reg <= 16'd7040;
            focal_x_reg     <= 12'd680;
            focal_y_reg     <= 12'd680;
            cam_y_reg       <= 16'd947;
            cam_z_reg       <= 16'd6349;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROW_SPLIT:   row_split_reg   <= cfg_data[11:0];
                REG_DEPTH_UPPER: depth_upper_reg <= cfg_data;
                REG_DEPTH_LOWER: depth_lower_reg <= cfg_data;
                REG_FOCAL_X:     focal_x_reg     <= cfg_data[11:0];
                REG_FOCAL_Y:     focal_y_reg     <= cfg_data[11:0];
                REG_CAM_Y:       cam_y_reg       <= cfg_data;
                REG_CAM_Z:       cam_z_reg       <= cfg_data;
                default:         ;
            endcase
        end
    end

    // A zero focal length is treated as one.
    assign fx = (focal_x_reg == 12'd0) ? 12'd1 : focal_x_reg;
    assign fy = (focal_y_reg == 12'd0) ? 12'd1 : focal_y_reg;

    // The pipeline moves as one whenever the output stage can take data.
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    assign pix_x = s_tdata[11:0];
    assign pix_y = s_tdata[23:12];
    assign depth = (pix_y < row_split_reg) ? depth_upper_reg : depth_lower_reg;

    // Input stage and restoring divider steps, one quotient bit per stage.
    always_comb
    begin
        logic [12:0] tx;
        logic [12:0] ty;
        div_next[0].by = $signed({1'b0, depth}) - $signed({1'b0, cam_y_reg});
        div_next[0].nx = 28'(pix_x * depth);
        div_next[0].ny = 28'(pix_y * depth);
        div_next[0].qx = '0;
        div_next[0].qy = '0;
        div_next[0].rx = '0;
        div_next[0].ry = '0;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            tx = {div_reg[k].rx, div_reg[k].nx[27]};
            ty = {div_reg[k].ry, div_reg[k].ny[27]};
            div_next[k+1].by = div_reg[k].by;
            div_next[k+1].nx = {div_reg[k].nx[26:0], 1'b0};
            div_next[k+1].ny = {div_reg[k].ny[26:0], 1'b0};
            div_next[k+1].qx = {div_reg[k].qx[26:0], (tx >= {1'b0, fx})};
            div_next[k+1].qy = {div_reg[k].qy[26:0], (ty >= {1'b0, fy})};
            div_next[k+1].rx = (tx >= {1'b0, fx}) ? 12'(tx - {1'b0, fx}) : tx[11:0];
            div_next[k+1].ry = (ty >= {1'b0, fy}) ? 12'(ty - {1'b0, fy}) : ty[11:0];
        end
    end

    // Setup of the base coordinates and CORDIC vectoring steps.
    always_comb
    begin
        logic signed [28:0] bx;
        logic signed [29:0] bz;
        logic               hi;
        logic signed [47:0] dx;
        logic signed [47:0] dy;
        logic signed [31:0] du;
        logic signed [31:0] dv;
        bx = $signed({1'b0, div_reg[DIV_STEPS].qx});
        bz = $signed({14'd0, cam_z_reg}) - $signed({2'd0, div_reg[DIV_STEPS].qy});
        hi = (bz >= 30'(ROLL_HEIGHT));
        cor_next[0].bx   = bx;
        cor_next[0].by   = div_reg[DIV_STEPS].by;
        cor_next[0].bz   = bz;
        cor_next[0].high = hi;
        cor_next[0].zero = (bx == 29'sd0) && (div_reg[DIV_STEPS].by == 17'sd0);
        cor_next[0].vx   = {3'd0, bx, 16'd0};
        cor_next[0].vy   = {{15{div_reg[DIV_STEPS].by[16]}}, div_reg[DIV_STEPS].by, 16'd0};
        cor_next[0].u    = hi ? 32'(S_HI) : 32'(S_LO);
        cor_next[0].v    = '0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = cor_reg[i].vy >>> i;
            dy = cor_reg[i].vx >>> i;
            du = cor_reg[i].v >>> i;
            dv = cor_reg[i].u >>> i;
            cor_next[i+1] = cor_reg[i];
            if (!cor_reg[i].vy[47])
            begin
                cor_next[i+1].vx = cor_reg[i].vx + dx;
                cor_next[i+1].vy = cor_reg[i].vy - dy;
                cor_next[i+1].u  = cor_reg[i].u - du;
                cor_next[i+1].v  = cor_reg[i].v + dv;
            end
            else
            begin
                cor_next[i+1].vx = cor_reg[i].vx - dx;
                cor_next[i+1].vy = cor_reg[i].vy + dy;
                cor_next[i+1].u  = cor_reg[i].u + du;
                cor_next[i+1].v  = cor_reg[i].v - dv;
            end
        end
    end

    // Valid bits of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg <= '0;
            cor_vld_reg <= '0;
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            div_vld_reg <= {div_vld_reg[DIV_STEPS-1:0], s_tvalid};
            cor_vld_reg <= {cor_vld_reg[CORDIC_STEPS-1:0], div_vld_reg[DIV_STEPS]};
            mul_vld_reg <= cor_vld_reg[CORDIC_STEPS];
            out_vld_reg <= mul_vld_reg;
        end
    end

    // Payload of all stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                div_reg[k] <= div_next[k];
            end
            for (int i = 0; i <= CORDIC_STEPS; i++)
            begin
                cor_reg[i] <= cor_next[i];
            end
            mul_reg  <= cor_reg[CORDIC_STEPS];
            mulx_reg <= 50'(cor_reg[CORDIC_STEPS].u) * 50'(INVK_Q16);
            muly_reg <= 50'(cor_reg[CORDIC_STEPS].v) * 50'(INVK_Q16);
            out_data_reg <= out_data_next;
        end
    end

    // Gain correction, claw offset and saturation.
    always_comb
    begin
        rx = mulx_reg + 50'sd2147483648;
        ry = muly_reg + 50'sd2147483648;
        if (mul_reg.zero)
        begin
            offx = mul_reg.high ? 18'(OFFX0_HI) : 18'(OFFX0_LO);
            offy = '0;
        end
        else
        begin
            offx = rx[49:32];
            offy = ry[49:32];
        end
        offz = mul_reg.high ? 18'(OFFZ_HI) : 18'(OFFZ_LO);
        out_data_next = {5'd0,
                         mul_reg.high ? ROLL_HI : ROLL_LO,
                         sat17(34'(mul_reg.bz) + 34'(offz)),
                         sat17(34'(mul_reg.by) - 34'(offy)),
                         sat17(34'(mul_reg.bx) - 34'(offx))};
    end

endmodule

FILE: rtl/ptg_chk.sv
// ----------------------------------------------------------------------------
// ptg_chk
// Port-level checks of the pixel to gripper position core.
// ----------------------------------------------------------------------------
module ptg_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    import ptg_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result holds its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Input is taken exactly when the output side can move.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // Roll is one of the two fixed angles.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[58:51] == ROLL_HI) || (m_tdata[58:51] == ROLL_LO))
        else $error("bad roll angle");

endmodule

bind pixel_to_gripper_position_core ptg_chk u_ptg_chk (.*);
